/* hw/rtl/bft_pkg.sv */
`default_nettype none
package bft_pkg;
    localparam int unsigned TableDepth = 16;
    localparam int unsigned SlotW = 4;
    localparam int unsigned CntW = 5;

    localparam logic [1:0] CmdPacket = 2'd0;
    localparam logic [1:0] CmdSweep = 2'd1;
    localparam logic [1:0] CmdList = 2'd2;
    localparam logic [1:0] CmdNone = 2'd3;

    localparam logic [2:0] OutHit = 3'd0;
    localparam logic [2:0] OutNew = 3'd1;
    localparam logic [2:0] OutFull = 3'd2;
    localparam logic [2:0] OutSweep = 3'd3;
    localparam logic [2:0] OutListed = 3'd4;
    localparam logic [2:0] OutEmpty = 3'd5;

    localparam logic [1:0] StFin = 2'd2;
    localparam logic [1:0] StClosed = 2'd3;

    typedef struct packed {
        logic [31:0] lo_ip;
        logic [15:0] lo_port;
        logic [31:0] hi_ip;
        logic [15:0] hi_port;
        logic [7:0]  proto;
    } t_key;

    typedef struct packed {
        t_key        key;
        logic [1:0]  state;
        logic [31:0] packets;
        logic [31:0] seen_time;
    } t_entry;

    // memory access request from the sequencer
    typedef struct packed {
        logic            we;
        logic [SlotW-1:0] waddr;
        t_entry          wdata;
        logic [SlotW-1:0] raddr;
    } t_mem_req;
endpackage
`default_nettype wire

/* hw/rtl/bidirectional_flow_table_top.sv */
`default_nettype none
// bidirectional flow table, 16 slots
// command channel: raise start with the item fields while busy is low;
// the item is taken on that edge and busy is high from the next cycle.
// results come out one per o_valid pulse; o_last marks the final result
// of an item. the receiver cannot stall the block.
// every command walks all 16 slots through the entry memory, one read a
// cycle with a registered read; an item passes an issue cycle, the slot
// reads, a finish cycle and a result cycle. the next item can be taken
// in the result cycle.
// a packet hit or insert writes the memory in the finish cycle; a sweep
// only clears valid bits, which are flip-flops next to the memory.
// list results leave one per valid non-closed slot, the last with o_last.
// idle timeout is written by i_cfg_we/i_cfg_data, by the user only while
// the block is idle; the block itself does not enforce it. synchronous
// active-low reset clears the valid bits and sets the timeout to 60;
// unwritten memory words are read but never used. cmd 3 gives no result.
module bidirectional_flow_table_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cfg_we,
    input  wire logic [30:0] i_cfg_data,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [31:0] i_time_now,
    input  wire logic [31:0] i_src_ip,
    input  wire logic [31:0] i_dst_ip,
    input  wire logic [15:0] i_src_port,
    input  wire logic [15:0] i_dst_port,
    input  wire logic [7:0]  i_proto_num,
    input  wire logic [1:0]  i_status_code,
    output logic             o_valid,
    output logic [2:0]       o_outcome,
    output logic [3:0]       o_slot,
    output logic [1:0]       o_flow_state,
    output logic [31:0]      o_packets,
    output logic [31:0]      o_low_ip,
    output logic [15:0]      o_low_port,
    output logic [31:0]      o_high_ip,
    output logic [15:0]      o_high_port,
    output logic [7:0]       o_flow_proto,
    output logic [4:0]       o_tally,
    output logic             o_last
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } t_state;

    localparam int unsigned SW = bft_pkg::SlotW;
    localparam int unsigned CW = bft_pkg::CntW;

    t_state r_st, n_st;
    logic [30:0] r_timeout;
    logic [bft_pkg::TableDepth-1:0] r_vld;
    logic [1:0] r_cmd;
    logic [31:0] r_now;
    logic [1:0] r_status;
    bft_pkg::t_key r_key;
    logic [SW:0] r_ridx;    // read issue index
    logic [SW:0] r_cidx;    // index of data arriving
    logic r_rd_pend;
    logic r_hit, r_free_found;
    logic [SW-1:0] r_hit_slot, r_free_slot;
    bft_pkg::t_entry r_hit_ent;
    logic [CW-1:0] r_removed;
    logic r_listed_any;
    // pending list record held one slot to find the last one
    logic r_pend;
    bft_pkg::t_entry r_pend_ent;
    logic [SW-1:0] r_pend_slot;

    bft_pkg::t_mem_req mem_req;
    bft_pkg::t_entry rdata;
    bft_pkg::t_key in_key;
    logic [CW-1:0] occ;
    logic [SW-1:0] cslot;
    logic cvld;
    logic [31:0] age;

    bft_ram u_ram (.i_clk(i_clk), .i_req(mem_req), .o_rdata(rdata));

    // direction normalisation
    always_comb begin
        if (i_src_ip < i_dst_ip || (i_src_ip == i_dst_ip && i_src_port <= i_dst_port)) begin
            in_key.lo_ip = i_src_ip;   in_key.lo_port = i_src_port;
            in_key.hi_ip = i_dst_ip;   in_key.hi_port = i_dst_port;
        end else begin
            in_key.lo_ip = i_dst_ip;   in_key.lo_port = i_dst_port;
            in_key.hi_ip = i_src_ip;   in_key.hi_port = i_src_port;
        end
        in_key.proto = i_proto_num;
    end

    // occupied count
    always_comb begin
        occ = '0;
        for (int i = 0; i < bft_pkg::TableDepth; i++) begin
            occ = occ + CW'(r_vld[i]);
        end
    end

    assign busy = (r_st != S_IDLE);
    assign cslot = r_cidx[SW-1:0];
    assign cvld = r_rd_pend && r_vld[cslot];
    assign age = r_now - rdata.seen_time;

    // memory request, write happens in the finish cycle of a packet
    always_comb begin
        mem_req.raddr = r_ridx[SW-1:0];
        mem_req.we = 1'b0;
        mem_req.waddr = r_hit ? r_hit_slot : r_free_slot;
        mem_req.wdata = r_hit_ent;
        if (r_hit) begin
            mem_req.wdata.packets = (r_hit_ent.packets == 32'hFFFF_FFFF)
                ? r_hit_ent.packets : r_hit_ent.packets + 32'd1;
            mem_req.wdata.seen_time = r_now;
            if (r_status == bft_pkg::StFin || r_status == bft_pkg::StClosed) begin
                mem_req.wdata.state = r_status;
            end
        end else begin
            mem_req.wdata.key = r_key;
            mem_req.wdata.state = r_status;
            mem_req.wdata.packets = 32'd1;
            mem_req.wdata.seen_time = r_now;
        end
        if (r_st == S_DONE && r_cmd == bft_pkg::CmdPacket && (r_hit || r_free_found)) begin
            mem_req.we = 1'b1;
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (start && i_cmd != bft_pkg::CmdNone) n_st = S_WALK;
            S_WALK: if (r_rd_pend && r_cidx == (SW+1)'(bft_pkg::TableDepth - 1)) n_st = S_DONE;
            S_DONE: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_timeout <= 31'd60;
            r_vld <= '0;
            r_rd_pend <= 1'b0;
            o_valid <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_st <= n_st;
            o_valid <= 1'b0;
            if (i_cfg_we) r_timeout <= i_cfg_data;
            if (r_st == S_WALK) begin
                r_rd_pend <= (r_ridx != (SW+1)'(bft_pkg::TableDepth));
                if (cvld && r_cmd == bft_pkg::CmdSweep &&
                    (age > {1'b0, r_timeout} || rdata.state == bft_pkg::StClosed)) begin
                    r_vld[cslot] <= 1'b0;
                end
                if (cvld && r_cmd == bft_pkg::CmdList && rdata.state != bft_pkg::StClosed) begin
                    r_pend <= 1'b1;
                    if (r_pend) o_valid <= 1'b1;
                end
            end else begin
                r_rd_pend <= 1'b0;
            end
            if (r_st == S_DONE) begin
                r_pend <= 1'b0;
                o_valid <= 1'b1;
                if (r_cmd == bft_pkg::CmdPacket && !r_hit && r_free_found) begin
                    r_vld[r_free_slot] <= 1'b1;
                end
            end
        end
    end

    // datapath and results
    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE) begin
            r_cmd <= i_cmd;
            r_now <= i_time_now;
            r_status <= i_status_code;
            r_key <= in_key;
            r_ridx <= '0;
            r_cidx <= '0;
            r_hit <= 1'b0;
            r_free_found <= 1'b0;
            r_removed <= '0;
            r_listed_any <= 1'b0;
        end
        if (r_st == S_WALK) begin
            if (r_ridx != (SW+1)'(bft_pkg::TableDepth)) r_ridx <= r_ridx + 1'b1;
            if (r_rd_pend) begin
                r_cidx <= r_cidx + 1'b1;
                if (cvld && !r_hit && rdata.key == r_key) begin
                    r_hit <= 1'b1;
                    r_hit_slot <= cslot;
                    r_hit_ent <= rdata;
                end
                if (!r_vld[cslot] && !r_free_found && !r_hit) begin
                    r_free_found <= 1'b1;
                    r_free_slot <= cslot;
                end
                if (cvld && (age > {1'b0, r_timeout} || rdata.state == bft_pkg::StClosed)) begin
                    r_removed <= r_removed + 1'b1;
                end
                if (cvld && rdata.state != bft_pkg::StClosed) begin
                    r_listed_any <= 1'b1;
                    r_pend_ent <= rdata;
                    r_pend_slot <= cslot;
                end
            end
        end
        // result fields
        o_outcome <= bft_pkg::OutListed;
        o_slot <= r_pend_slot;
        o_flow_state <= r_pend_ent.state;
        o_packets <= r_pend_ent.packets;
        o_low_ip <= r_pend_ent.key.lo_ip;
        o_low_port <= r_pend_ent.key.lo_port;
        o_high_ip <= r_pend_ent.key.hi_ip;
        o_high_port <= r_pend_ent.key.hi_port;
        o_flow_proto <= r_pend_ent.key.proto;
        o_tally <= occ;
        o_last <= 1'b0;
        if (r_st == S_DONE) begin
            o_last <= 1'b1;
            case (r_cmd)
                bft_pkg::CmdPacket: begin
                    if (r_hit) begin
                        o_outcome <= bft_pkg::OutHit;
                        o_slot <= r_hit_slot;
                        o_flow_state <= mem_req.wdata.state;
                        o_packets <= mem_req.wdata.packets;
                        o_tally <= occ;
                    end else if (r_free_found) begin
                        o_outcome <= bft_pkg::OutNew;
                        o_slot <= r_free_slot;
                        o_flow_state <= r_status;
                        o_packets <= 32'd1;
                        o_tally <= occ + 1'b1;
                    end else begin
                        o_outcome <= bft_pkg::OutFull;
                        o_slot <= '0;
                        o_flow_state <= '0;
                        o_packets <= '0;
                    end
                    o_low_ip <= r_key.lo_ip;
                    o_low_port <= r_key.lo_port;
                    o_high_ip <= r_key.hi_ip;
                    o_high_port <= r_key.hi_port;
                    o_flow_proto <= r_key.proto;
                end
                bft_pkg::CmdSweep: begin
                    o_outcome <= bft_pkg::OutSweep;
                    o_slot <= '0; o_flow_state <= '0; o_packets <= '0;
                    o_low_ip <= '0; o_low_port <= '0; o_high_ip <= '0;
                    o_high_port <= '0; o_flow_proto <= '0;
                    o_tally <= r_removed;
                end
                default: begin
                    if (!r_listed_any) begin
                        o_outcome <= bft_pkg::OutEmpty;
                        o_slot <= '0; o_flow_state <= '0; o_packets <= '0;
                        o_low_ip <= '0; o_low_port <= '0; o_high_ip <= '0;
                        o_high_port <= '0; o_flow_proto <= '0;
                    end
                end
            endcase
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/bft_ram.sv */
`default_nettype none
module bft_ram (
    input  wire logic              i_clk,
    input  wire bft_pkg::t_mem_req i_req,
    output bft_pkg::t_entry        o_rdata
);
    bft_pkg::t_entry r_mem [bft_pkg::TableDepth];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end
endmodule
`default_nettype wire
